// ----- hdl/stwr_pkg.sv -----
`timescale 1ns / 1ps

package stwr_pkg;

  // default window geometry
  localparam int COLUMNS_DEF = 18;
  localparam int ROWS_DEF    = 4;

  // fixed result field widths
  localparam int ROW_W  = 3;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 7;

  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  function automatic logic is_newline(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(input logic [7:0] c);
    logic [CHAR_W-1:0] g;
    if (is_newline(c)) begin
      g = CH_STAR[CHAR_W-1:0];
    end else if ((c >= CH_SPACE) && (c <= CH_TILDE)) begin
      g = c[CHAR_W-1:0];
    end else begin
      g = CH_DOT[CHAR_W-1:0];
    end
    return g;
  endfunction

endpackage

// ----- hdl/stwr_ring.sv -----
`timescale 1ns / 1ps

module stwr_ring #(
  parameter int DEPTH = stwr_pkg::COLUMNS_DEF * stwr_pkg::ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  import stwr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [7:0]       data_r;
  logic             vld_r;
  logic [AW-1:0]    addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_r <= mem[rd_addr];
    addr_r <= rd_addr;
  end

  // per-entry written flags, an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      vld_r <= written_r[rd_addr];
    end
  end

  assign rd_data = vld_r ? data_r : ((addr_r == LAST_ADDR) ? CH_LF : CH_PLUS);

endmodule

// ----- hdl/serial_text_window_renderer_core.sv -----
`timescale 1ns / 1ps
// a taken byte is written, the slot after it is blanked, the write slot is read, the backward
//   walk checks ROWS+2 to COLUMNS*ROWS entries, the window start is read, and the forward walk
//   covers up to COLUMNS*ROWS-1 entries, one ring read per cycle on the single read port
// a stalled result port holds the forward walk; a new byte is taken once the walk ends
// reset: synchronous active-low; ring reads as '+' with a newline in the last entry,
//   write index zero, no result pending

module serial_text_window_renderer_core #(
  parameter int COLUMNS = stwr_pkg::COLUMNS_DEF,
  parameter int ROWS    = stwr_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats: one received byte each
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result beats: one character pair each
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] row, [7:3] column, [14:8] first_char,
                                  // [21:15] second_char, [23:22] zero
  output logic        out_tuser,  // [0] second_valid
  output logic        out_tlast   // final pair of this refresh
);
  import stwr_pkg::*;

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LNW   = $clog2(ROWS + 2);     // lines seen by the backward walk
  localparam int SNW   = $clog2(COLUMNS);      // chars since last newline
  localparam int SCW   = $clog2(DEPTH + 1);    // entries searched
  localparam int LENW  = $clog2(COLUMNS + 1);  // chars in current row
  localparam int RLW   = $clog2(ROWS + 1);     // current output row

  localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [LNW-1:0]  LINES_MAX = LNW'(ROWS + 1);
  localparam logic [SNW-1:0]  SINCE_LIM = SNW'(COLUMNS - 1);
  localparam logic [SCW-1:0]  SRCH_MAX  = SCW'(DEPTH);
  localparam logic [LENW-1:0] LEN_MAX   = LENW'(COLUMNS);
  localparam logic [RLW-1:0]  ROW_LAST  = RLW'(ROWS);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a byte
  localparam logic [2:0] S_SPACE = 3'd1;  // blank the slot after the new byte
  localparam logic [2:0] S_SPREP = 3'd2;  // read the write slot
  localparam logic [2:0] S_SRCH  = 3'd3;  // backward walk, one entry a cycle
  localparam logic [2:0] S_RPREP = 3'd4;  // read the window start
  localparam logic [2:0] S_REND  = 3'd5;  // forward walk, emit pairs

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_ADDR : p - 1'b1;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     wi_r, wi_nxt;          // write index
  logic [AW-1:0]     p_r, p_nxt;            // address of the entry on the read data
  logic [SCW-1:0]    searched_r, searched_nxt;
  logic [LNW-1:0]    lines_r, lines_nxt;
  logic [SNW-1:0]    since_r, since_nxt;
  logic [LENW-1:0]   len_r, len_nxt;
  logic [RLW-1:0]    rline_r, rline_nxt;
  logic [CHAR_W-1:0] first_r, first_nxt;    // held first glyph of a pair
  logic              have_first_r, have_first_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;
  logic              out_last_r, out_last_nxt;

  // ring port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;

  // per-entry evaluation terms
  logic              nl;
  logic [CHAR_W-1:0] g;
  logic [AW-1:0]     p_fwd, p_back, cand;
  logic              at_wi, row_end, all_end, emit, advance, out_room;
  logic [LENW-1:0]   len_inc;
  logic [LNW-1:0]    lines_inc;
  logic [SCW-1:0]    searched_inc;
  logic              srch_done;
  logic [CHAR_W-1:0] pair_a, pair_b;
  logic [LENW-1:0]   pair_col;

  stwr_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_room  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    wi_nxt         = wi_r;
    p_nxt          = p_r;
    searched_nxt   = searched_r;
    lines_nxt      = lines_r;
    since_nxt      = since_r;
    len_nxt        = len_r;
    rline_nxt      = rline_r;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;

    wr_en   = 1'b0;
    wr_addr = wi_r;
    wr_data = in_tdata;
    rd_addr = p_r;

    nl           = is_newline(rd_data);
    g            = glyph(rd_data);
    p_fwd        = ring_next(p_r);
    p_back       = ring_prev(p_r);
    at_wi        = (p_fwd == wi_r);
    len_inc      = len_r + 1'b1;
    lines_inc    = lines_r + 1'b1;
    searched_inc = searched_r + 1'b1;
    row_end      = nl || (len_inc == LEN_MAX) || at_wi;
    all_end      = at_wi || (row_end && (rline_r == ROW_LAST));
    emit         = have_first_r || row_end;
    advance      = !emit || out_room;
    srch_done    = 1'b0;
    cand         = p_back;

    if (have_first_r) begin
      pair_a   = first_r;
      pair_b   = g;
      pair_col = len_r - 1'b1;
    end else begin
      pair_a   = g;
      pair_b   = CH_SPACE[CHAR_W-1:0];
      pair_col = len_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          wr_en   = 1'b1;
          wr_addr = wi_r;
          wr_data = in_tdata;
          wi_nxt  = ring_next(wi_r);
          state_nxt = S_SPACE;
        end
      end
      S_SPACE: begin
        wr_en     = 1'b1;
        wr_addr   = wi_r;
        wr_data   = CH_SPACE;
        state_nxt = S_SPREP;
      end
      S_SPREP: begin
        rd_addr      = wi_r;
        p_nxt        = wi_r;
        searched_nxt = '0;
        lines_nxt    = '0;
        since_nxt    = '0;
        state_nxt    = S_SRCH;
      end
      S_SRCH: begin
        // the read issued now is the entry the walk looks at next
        rd_addr = p_back;
        if (nl) begin
          if (lines_inc == LINES_MAX) begin
            srch_done = 1'b1;
            cand      = p_fwd;
          end else begin
            lines_nxt    = lines_inc;
            since_nxt    = '0;
            searched_nxt = searched_inc;
            p_nxt        = p_back;
          end
        end else begin
          if ((since_r >= SINCE_LIM) && (lines_inc >= LINES_MAX)) begin
            // a wrapped row fills the window
            srch_done = 1'b1;
            cand      = p_fwd;
          end else if (since_r >= SINCE_LIM) begin
            lines_nxt    = lines_inc;
            since_nxt    = SNW'(1);
            searched_nxt = searched_inc;
            p_nxt        = p_back;
          end else begin
            since_nxt    = since_r + 1'b1;
            searched_nxt = searched_inc;
            p_nxt        = p_back;
          end
        end
        // whole ring walked: the walk is back on the write slot
        if (!srch_done && (searched_inc == SRCH_MAX)) begin
          srch_done = 1'b1;
          cand      = p_back;
        end
        if (srch_done) begin
          // never start on the write slot itself
          p_nxt          = (cand == wi_r) ? ring_next(wi_r) : cand;
          len_nxt        = '0;
          rline_nxt      = '0;
          have_first_nxt = 1'b0;
          state_nxt      = S_RPREP;
        end
      end
      S_RPREP: begin
        rd_addr   = p_r;
        state_nxt = S_REND;
      end
      S_REND: begin
        // a stall re-reads the same entry so the read data stays in step
        rd_addr = advance ? p_fwd : p_r;
        if (emit && out_room) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, pair_b, pair_a, COL_W'(pair_col), ROW_W'(rline_r)};
          out_user_nxt  = have_first_r;
          out_last_nxt  = all_end;
        end
        if (advance) begin
          p_nxt = p_fwd;
          if (emit) begin
            have_first_nxt = 1'b0;
          end else begin
            first_nxt      = g;
            have_first_nxt = 1'b1;
          end
          if (all_end) begin
            state_nxt = S_IDLE;
          end else if (row_end) begin
            rline_nxt = rline_r + 1'b1;
            len_nxt   = '0;
          end else begin
            len_nxt = len_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wi_r         <= '0;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wi_r         <= wi_nxt;
      have_first_r <= have_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    searched_r <= searched_nxt;
    lines_r    <= lines_nxt;
    since_r    <= since_nxt;
    len_r      <= len_nxt;
    rline_r    <= rline_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
